@@ rtl/lbvh_pkg.sv @@
// Shared types, constants and codes of the log-binned velocity histogram.
package lbvh_pkg;

  // Histogram geometry.
  localparam int unsigned BINS_AXIAL     = 16;
  localparam int unsigned BINS_RADIAL    = 16;
  localparam int unsigned BINS_AZIMUTHAL = 16;
  localparam int unsigned HALF_AXIAL     = BINS_AXIAL / 2;
  localparam int unsigned HALF_RADIAL    = BINS_RADIAL / 2;
  localparam int unsigned HALF_AZIMUTHAL = BINS_AZIMUTHAL / 2;
  localparam int unsigned BIN_AX_W  = $clog2(BINS_AXIAL);
  localparam int unsigned BIN_RAD_W = $clog2(BINS_RADIAL);
  localparam int unsigned BIN_AZI_W = $clog2(BINS_AZIMUTHAL);
  localparam int unsigned CELLS     = BINS_AXIAL * BINS_RADIAL * BINS_AZIMUTHAL;
  localparam int unsigned ADDR_W    = $clog2(CELLS);

  // Field and datapath widths.
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned CELL_W   = 48;
  localparam int unsigned BIN_OUT_W = 4;
  localparam int unsigned WIDE_W   = 36;  // rotated values grow past 32 bits
  localparam int unsigned X_W      = 38;  // |d| + 1.0 before normalizing
  localparam int unsigned ITER_W   = 5;
  localparam int unsigned CORDIC_LAST = 31;
  localparam int unsigned SQ_LAST     = 15;
  localparam int unsigned RAW_W    = 14;

  // 1/gain of the CORDIC in Q0.30.
  localparam logic [29:0] INV_GAIN = 30'd652032874;
  localparam logic [X_W-1:0] ONE_Q16 = X_W'(65536);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CENTER_AX  = 3'd0,
    CFG_CENTER_RAD = 3'd1,
    CFG_CENTER_AZI = 3'd2,
    CFG_SCALE_AX   = 3'd3,
    CFG_SCALE_RAD  = 3'd4,
    CFG_SCALE_AZI  = 3'd5
  } cfg_idx_e;

  // Axis being binned.
  typedef enum logic [1:0] {
    AXIS_AX  = 2'd0,
    AXIS_RAD = 2'd1,
    AXIS_AZI = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CORDIC,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_GAIN_FIN,
    ST_LOG_LOAD,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_BIN_MUL,
    ST_BIN_FIN,
    ST_MEM_RD,
    ST_MEM_WB
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              cordic_step;
    logic [ITER_W-1:0] iter;
    logic              gain_lo;
    logic              gain_hi;
    logic              gain_fin;
    logic              log_load;
    axis_e             axis;
    logic              norm_step;
    logic              sq_init;
    logic              sq_step;
    logic              bin_mul;
    logic              bin_fin;
    logic              mem_rd;
    logic              mem_wb;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic origin;
    logic normalized;
    logic out_busy;
  } dp_status_t;

endpackage

@@ rtl/log_binned_velocity_histogram.sv @@
// Top level of the log-binned 3-D velocity histogram.
// A new sample word is accepted only after the previous one has been written
// back to the histogram, and that write-back waits until the earlier result
// word has been taken. A sample at the position origin skips the rotation.
// Any other sample runs 32 CORDIC iterations and a gain correction. Then the
// three axes pass one after another through a log2 unit (normalizing steps
// and 16 squarings on one shared 32x32 multiplier) and a scale multiply, and
// the histogram cell is read and written back. One sample is worked on at a
// time; the result word waits in an output register while the next sample is
// accepted. After reset a clearing pass zeroes all 4096 histogram cells,
// during which no sample is accepted. Configuration writes are taken at any
// time, but they should be issued only while no sample is in progress.
module log_binned_velocity_histogram (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Sample words.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vel_axial[31:0], vel_trans_a[63:32], vel_trans_b[95:64],
  // pos_trans_a[127:96], pos_trans_b[159:128], weight[191:160]
  input  logic [191:0] s_axis_tdata,
  // Result words.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bin_axial[3:0], bin_radial[7:4], bin_azimuthal[11:8],
  // cell_total[59:12], saturated[60], zero[63:61]
  output logic [63:0]  m_axis_tdata,
  // Configuration writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);
  import lbvh_pkg::*;

  dp_cmd_t           cmd;
  dp_status_t        status;
  ctrl_state_e       state;
  logic [BIN_OUT_W-1:0] bin_ax, bin_rad, bin_azi;
  logic [CELL_W-1:0] cell_total;
  logic              saturated;

  assign cfg_ready_o = 1'b1;

  lbvh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  lbvh_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_valid_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .vel_axial_i     (s_axis_tdata[31:0]),
    .vel_trans_a_i   (s_axis_tdata[63:32]),
    .vel_trans_b_i   (s_axis_tdata[95:64]),
    .pos_trans_a_i   (s_axis_tdata[127:96]),
    .pos_trans_b_i   (s_axis_tdata[159:128]),
    .weight_i        (s_axis_tdata[191:160]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .bin_axial_o     (bin_ax),
    .bin_radial_o    (bin_rad),
    .bin_azimuthal_o (bin_azi),
    .cell_total_o    (cell_total),
    .saturated_o     (saturated)
  );

  // Pack the result word.
  assign m_axis_tdata = {3'b000, saturated, cell_total, bin_azi, bin_rad, bin_ax};

`ifndef SYNTHESIS
  // A sample is not taken while the previous one is still in flight.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample accepted while another is in progress");

  // A saturated cell reports the maximum total.
  a_sat_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[60] |-> m_axis_tdata[59:12] == '1)
    else $error("saturated flag without a full-scale total");

  // A result appears only out of the write-back step.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state == ST_MEM_WB))
    else $error("result word raised outside write-back");

  // No sample is taken during the clearing pass.
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == ST_CLEAR |-> !s_axis_tready)
    else $error("sample ready during histogram clear");
`endif

endmodule

@@ rtl/lbvh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lbvh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lbvh_datapath.sv @@
// Datapath: configuration registers, CORDIC, gain fix, log2, binning and histogram update.
module lbvh_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbvh_pkg::dp_cmd_t           cmd_i,
  output lbvh_pkg::dp_status_t        status_o,
  // Configuration writes.
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_addr_i,
  input  logic [31:0]                 cfg_data_i,
  // Input fields.
  input  logic [lbvh_pkg::VAL_W-1:0]  vel_axial_i,
  input  logic [lbvh_pkg::VAL_W-1:0]  vel_trans_a_i,
  input  logic [lbvh_pkg::VAL_W-1:0]  vel_trans_b_i,
  input  logic [lbvh_pkg::VAL_W-1:0]  pos_trans_a_i,
  input  logic [lbvh_pkg::VAL_W-1:0]  pos_trans_b_i,
  input  logic [lbvh_pkg::VAL_W-1:0]  weight_i,
  // Result word.
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [lbvh_pkg::BIN_OUT_W-1:0] bin_axial_o,
  output logic [lbvh_pkg::BIN_OUT_W-1:0] bin_radial_o,
  output logic [lbvh_pkg::BIN_OUT_W-1:0] bin_azimuthal_o,
  output logic [lbvh_pkg::CELL_W-1:0] cell_total_o,
  output logic                        saturated_o
);
  import lbvh_pkg::*;

  // Configuration registers.
  logic signed [VAL_W-1:0] center_ax_q, center_rad_q, center_azi_q;
  logic [SCALE_W-1:0]      scale_ax_q, scale_rad_q, scale_azi_q;

  // Sample registers.
  logic [VAL_W-1:0]        vax_q, w_q;
  logic signed [WIDE_W-1:0] pa_q, pb_q, va_q, vb_q;
  logic signed [WIDE_W-1:0] pa_d, pb_d, va_d, vb_d;
  logic                    origin_q;

  // Gain fix.
  logic [63:0]             acc_q;
  logic signed [WIDE_W-1:0] gain_v;
  logic [WIDE_W-1:0]       gain_mag;
  logic [63:0]             acc_round;
  logic [WIDE_W-1:0]       gain_res;

  // Log2 unit.
  logic [X_W-1:0]          x_q;
  logic [5:0]              p_q;
  logic                    dneg_q;
  logic [31:0]             m_q;
  logic [15:0]             frac_q;
  logic [63:0]             sq_prod;
  logic [32:0]             sq_shr;
  logic signed [WIDE_W-1:0] vel_sel;
  logic signed [VAL_W-1:0] center_sel;
  logic [SCALE_W-1:0]      scale_sel;
  logic signed [WIDE_W:0]  d_val;
  logic [WIDE_W:0]         d_mag;

  // Bin computation.
  logic [45:0]             bprod_q;
  logic [21:0]             log_val;
  logic [RAW_W-1:0]        raw, half_sel, bin_val;
  logic [BIN_AX_W-1:0]     bin_ax_q;
  logic [BIN_RAD_W-1:0]    bin_rad_q;
  logic [BIN_AZI_W-1:0]    bin_azi_q;

  // Histogram memory.
  logic [ADDR_W-1:0]       cell_idx;
  logic [31:0]             idx_full;
  logic [CELL_W-1:0]       rdata;
  logic [CELL_W:0]         sum;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [CELL_W-1:0]       ram_wdata;
  logic [CELL_W-1:0]       total;

  // Result register.
  logic                    out_valid_q;
  logic [BIN_OUT_W-1:0]    out_ax_q, out_rad_q, out_azi_q;
  logic [CELL_W-1:0]       out_total_q;
  logic                    out_sat_q;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_ax_q  <= '0;
      center_rad_q <= '0;
      center_azi_q <= '0;
      scale_ax_q   <= SCALE_W'(65536);
      scale_rad_q  <= SCALE_W'(65536);
      scale_azi_q  <= SCALE_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_CENTER_AX:  center_ax_q  <= cfg_data_i;
        CFG_CENTER_RAD: center_rad_q <= cfg_data_i;
        CFG_CENTER_AZI: center_azi_q <= cfg_data_i;
        CFG_SCALE_AX:   scale_ax_q   <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_RAD:  scale_rad_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_AZI:  scale_azi_q  <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample load, half-turn for a negative first position, CORDIC steps and gain results.
  always_comb begin
    pa_d = pa_q;
    pb_d = pb_q;
    va_d = va_q;
    vb_d = vb_q;
    if (cmd_i.load) begin
      pa_d = {{(WIDE_W-VAL_W){pos_trans_a_i[VAL_W-1]}}, pos_trans_a_i};
      pb_d = {{(WIDE_W-VAL_W){pos_trans_b_i[VAL_W-1]}}, pos_trans_b_i};
      va_d = {{(WIDE_W-VAL_W){vel_trans_a_i[VAL_W-1]}}, vel_trans_a_i};
      vb_d = {{(WIDE_W-VAL_W){vel_trans_b_i[VAL_W-1]}}, vel_trans_b_i};
      if (pos_trans_a_i[VAL_W-1]) begin
        pa_d = -pa_d;
        pb_d = -pb_d;
        va_d = -va_d;
        vb_d = -vb_d;
      end
    end else if (cmd_i.cordic_step) begin
      if (!pb_q[WIDE_W-1]) begin
        pa_d = pa_q + (pb_q >>> cmd_i.iter);
        pb_d = pb_q - (pa_q >>> cmd_i.iter);
        va_d = va_q + (vb_q >>> cmd_i.iter);
        vb_d = vb_q - (va_q >>> cmd_i.iter);
      end else begin
        pa_d = pa_q - (pb_q >>> cmd_i.iter);
        pb_d = pb_q + (pa_q >>> cmd_i.iter);
        va_d = va_q - (vb_q >>> cmd_i.iter);
        vb_d = vb_q + (va_q >>> cmd_i.iter);
      end
    end else if (cmd_i.gain_fin) begin
      if (cmd_i.axis == AXIS_AZI) begin
        vb_d = gain_res;
      end else begin
        va_d = gain_res;
      end
    end
  end

  // Gain fix: magnitude times 1/gain in two partial products, then round.
  assign gain_v    = (cmd_i.axis == AXIS_AZI) ? vb_q : va_q;
  assign gain_mag  = gain_v[WIDE_W-1] ? WIDE_W'(-gain_v) : WIDE_W'(gain_v);
  assign acc_round = acc_q + 64'h2000_0000;
  assign gain_res  = gain_v[WIDE_W-1] ? -{2'b00, acc_round[63:30]}
                                      : {2'b00, acc_round[63:30]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vax_q    <= vel_axial_i;
      w_q      <= weight_i;
      origin_q <= (pos_trans_a_i == '0) && (pos_trans_b_i == '0);
    end
    pa_q <= pa_d;
    pb_q <= pb_d;
    va_q <= va_d;
    vb_q <= vb_d;
    if (cmd_i.gain_lo) begin
      acc_q <= 64'(gain_mag[17:0]) * 64'(INV_GAIN);
    end else if (cmd_i.gain_hi) begin
      acc_q <= acc_q + ((64'(gain_mag[35:18]) * 64'(INV_GAIN)) << 18);
    end
  end

  // Axis selection for the log2 unit.
  always_comb begin
    unique case (cmd_i.axis)
      AXIS_RAD: begin
        vel_sel    = va_q;
        center_sel = center_rad_q;
        scale_sel  = scale_rad_q;
        half_sel   = RAW_W'(HALF_RADIAL);
      end
      AXIS_AZI: begin
        vel_sel    = vb_q;
        center_sel = center_azi_q;
        scale_sel  = scale_azi_q;
        half_sel   = RAW_W'(HALF_AZIMUTHAL);
      end
      default: begin
        vel_sel    = {{(WIDE_W-VAL_W){vax_q[VAL_W-1]}}, vax_q};
        center_sel = center_ax_q;
        scale_sel  = scale_ax_q;
        half_sel   = RAW_W'(HALF_AXIAL);
      end
    endcase
  end

  assign d_val = {vel_sel[WIDE_W-1], vel_sel}
               - {{(WIDE_W+1-VAL_W){center_sel[VAL_W-1]}}, center_sel};
  assign d_mag = d_val[WIDE_W] ? (WIDE_W+1)'(-d_val) : (WIDE_W+1)'(d_val);

  // Squaring step of the fraction bits.
  assign sq_prod = 64'(m_q) * 64'(m_q);
  assign sq_shr  = sq_prod[63:31];

  // Log2: load |d| + 1.0, normalize a byte or a bit a cycle, then square.
  always_ff @(posedge clk_i) begin
    if (cmd_i.log_load) begin
      x_q    <= {1'b0, d_mag} + ONE_Q16;
      p_q    <= 6'(X_W - 1);
      dneg_q <= d_val[WIDE_W];
    end else if (cmd_i.norm_step) begin
      if (x_q[X_W-1 -: 8] == '0) begin
        x_q <= x_q << 8;
        p_q <= p_q - 6'd8;
      end else if (!x_q[X_W-1]) begin
        x_q <= x_q << 1;
        p_q <= p_q - 6'd1;
      end
    end
    if (cmd_i.sq_init) begin
      m_q    <= x_q[X_W-1 -: 32];
      frac_q <= '0;
    end else if (cmd_i.sq_step) begin
      if (sq_shr[32]) begin
        m_q    <= sq_shr[32:1];
        frac_q <= {frac_q[14:0], 1'b1};
      end else begin
        m_q    <= sq_shr[31:0];
        frac_q <= {frac_q[14:0], 1'b0};
      end
    end
  end

  // Bin: floor(log2 * scale), clamped to the half, offset for negative d.
  assign log_val = {p_q - 6'd16, frac_q};
  assign raw     = bprod_q[45:32];
  always_comb begin
    bin_val = (raw >= half_sel) ? half_sel - RAW_W'(1) : raw;
    if (dneg_q) begin
      bin_val = bin_val + half_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_mul) begin
      bprod_q <= 46'(log_val) * 46'(scale_sel);
    end
    if (cmd_i.bin_fin) begin
      unique case (cmd_i.axis)
        AXIS_RAD: bin_rad_q <= BIN_RAD_W'(bin_val);
        AXIS_AZI: bin_azi_q <= BIN_AZI_W'(bin_val);
        default:  bin_ax_q  <= BIN_AX_W'(bin_val);
      endcase
    end
  end

  // Histogram cell address and saturating update.
  assign idx_full = (32'(bin_ax_q) * 32'(BINS_RADIAL) + 32'(bin_rad_q))
                    * 32'(BINS_AZIMUTHAL) + 32'(bin_azi_q);
  assign cell_idx = idx_full[ADDR_W-1:0];
  assign sum      = {1'b0, rdata} + (CELL_W+1)'(w_q);
  assign total    = sum[CELL_W] ? '1 : sum[CELL_W-1:0];

  assign ram_we    = cmd_i.clr_we | cmd_i.mem_wb;
  assign ram_waddr = cmd_i.clr_we ? cmd_i.clr_addr : cell_idx;
  assign ram_wdata = cmd_i.clr_we ? '0 : total;

  lbvh_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (cell_idx),
    .rdata_o (rdata)
  );

  // Result register; holds the word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.mem_wb) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wb) begin
      out_ax_q    <= BIN_OUT_W'(bin_ax_q);
      out_rad_q   <= BIN_OUT_W'(bin_rad_q);
      out_azi_q   <= BIN_OUT_W'(bin_azi_q);
      out_total_q <= total;
      out_sat_q   <= sum[CELL_W];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bin_axial_o     = out_ax_q;
  assign bin_radial_o    = out_rad_q;
  assign bin_azimuthal_o = out_azi_q;
  assign cell_total_o    = out_total_q;
  assign saturated_o     = out_sat_q;

  assign status_o.origin     = origin_q;
  assign status_o.normalized = x_q[X_W-1];
  assign status_o.out_busy   = out_valid_q & ~out_ready_i;

endmodule

@@ rtl/lbvh_ctrl.sv @@
// Controller: sequences the clearing pass and the steps of one sample.
module lbvh_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  lbvh_pkg::dp_status_t    status_i,
  output lbvh_pkg::dp_cmd_t       cmd_o,
  output lbvh_pkg::ctrl_state_e   state_o
);
  import lbvh_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  axis_e             axis_q, axis_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      iter_q  <= '0;
      axis_q  <= AXIS_AX;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      axis_q  <= axis_d;
      clr_q   <= clr_d;
    end
  end

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    axis_d  = axis_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CORDIC;
          iter_d  = '0;
        end
      end
      ST_CORDIC: begin
        iter_d = iter_q + ITER_W'(1);
        if (status_i.origin) begin
          state_d = ST_LOG_LOAD;
          axis_d  = AXIS_AX;
        end else if (iter_q == ITER_W'(CORDIC_LAST)) begin
          state_d = ST_GAIN_LO;
          axis_d  = AXIS_RAD;
        end
      end
      ST_GAIN_LO: state_d = ST_GAIN_HI;
      ST_GAIN_HI: state_d = ST_GAIN_FIN;
      ST_GAIN_FIN: begin
        if (axis_q == AXIS_RAD) begin
          state_d = ST_GAIN_LO;
          axis_d  = AXIS_AZI;
        end else begin
          state_d = ST_LOG_LOAD;
          axis_d  = AXIS_AX;
        end
      end
      ST_LOG_LOAD: state_d = ST_LOG_NORM;
      ST_LOG_NORM: begin
        if (status_i.normalized) begin
          state_d = ST_LOG_SQ;
          iter_d  = '0;
        end
      end
      ST_LOG_SQ: begin
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(SQ_LAST)) begin
          state_d = ST_BIN_MUL;
        end
      end
      ST_BIN_MUL: state_d = ST_BIN_FIN;
      ST_BIN_FIN: begin
        unique case (axis_q)
          AXIS_AX: begin
            axis_d  = AXIS_RAD;
            state_d = ST_LOG_LOAD;
          end
          AXIS_RAD: begin
            axis_d  = AXIS_AZI;
            state_d = ST_LOG_LOAD;
          end
          default: state_d = ST_MEM_RD;
        endcase
      end
      ST_MEM_RD: state_d = ST_MEM_WB;
      ST_MEM_WB: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o          = '0;
    cmd_o.iter     = iter_q;
    cmd_o.axis     = axis_q;
    cmd_o.clr_addr = clr_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_we = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CORDIC:   cmd_o.cordic_step = ~status_i.origin;
      ST_GAIN_LO:  cmd_o.gain_lo = 1'b1;
      ST_GAIN_HI:  cmd_o.gain_hi = 1'b1;
      ST_GAIN_FIN: cmd_o.gain_fin = 1'b1;
      ST_LOG_LOAD: cmd_o.log_load = 1'b1;
      ST_LOG_NORM: begin
        cmd_o.norm_step = ~status_i.normalized;
        cmd_o.sq_init   = status_i.normalized;
      end
      ST_LOG_SQ:  cmd_o.sq_step = 1'b1;
      ST_BIN_MUL: cmd_o.bin_mul = 1'b1;
      ST_BIN_FIN: cmd_o.bin_fin = 1'b1;
      ST_MEM_RD:  cmd_o.mem_rd = 1'b1;
      ST_MEM_WB:  cmd_o.mem_wb = ~status_i.out_busy;
      default: ;
    endcase
  end

  assign state_o = state_q;

endmodule
